FILE: hw/rtl/sei_timecode_scanner_core_defines.svh
// Assertion macros for the SEI timecode scanner core.
`ifndef SEI_TIMECODE_SCANNER_CORE_DEFINES_SVH
`define SEI_TIMECODE_SCANNER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at every rising clock edge outside reset.
`define SEITS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("seits: implication check failed");
// Next-cycle implication.
`define SEITS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("seits: next-cycle check failed");
`else
`define SEITS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define SEITS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/seits_pkg.sv
// Shared types, constants and helpers for the SEI timecode scanner.
`timescale 1ns / 1ps
`default_nettype none
package seits_pkg;

   // Counter width (8 to 64); outputs carry the low 32 bits.
   localparam int COUNT_WIDTH = 32;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam int WIN_DEPTH = 32;
   localparam int ID_LEN    = 16;
   localparam int ID_BASE   = 4;    // first identifier byte in the window
   localparam int PAY_BASE  = 20;   // first payload byte in the window

   localparam logic [7:0] FILL_BYTE = 8'hff;

   localparam logic [7:0] HDR_AVC  [3] = '{8'h06, 8'h05, 8'h1c};
   localparam logic [7:0] HDR_HEVC [4] = '{8'h4e, 8'h01, 8'h05, 8'h1c};

   localparam logic [7:0] ID_AVC [ID_LEN] = '{
      8'h4d, 8'h49, 8'h53, 8'h50, 8'h6d, 8'h69, 8'h63, 8'h72,
      8'h6f, 8'h73, 8'h65, 8'h63, 8'h74, 8'h69, 8'h6d, 8'h65};
   localparam logic [7:0] ID_HEVC [ID_LEN] = '{
      8'ha8, 8'h68, 8'h7d, 8'hd4, 8'hd7, 8'h59, 8'h37, 8'h58,
      8'ha5, 8'hce, 8'hf0, 8'h33, 8'h8b, 8'h65, 8'h45, 8'hf1};

   // Result kinds.
   localparam logic KIND_FRAME   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Codec codes.
   localparam logic CODEC_AVC  = 1'b0;
   localparam logic CODEC_HEVC = 1'b1;

   // Result queue depth, power of two.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Index 0 is the oldest byte, WIN_DEPTH-1 the newest.
   typedef logic [WIN_DEPTH-1:0][7:0] window_type;

   typedef struct packed {
      logic        found;
      logic        hevc;
      logic [63:0] stamp;
      logic [7:0]  status;
   } match_type;

   typedef struct packed {
      logic        kind;
      logic [63:0] time_us;
      logic [63:0] first_time_us;
      logic [7:0]  status_byte;
      logic        lock_unknown;
      logic        codec;
      logic        went_backwards;
      logic [31:0] frame_count;
      logic [31:0] backwards_count;
      logic        last_of_run;
   } result_type;

   function automatic logic [31:0] count_to_out(input logic [COUNT_WIDTH-1:0] c);
      logic [63:0] wide;
      wide = 64'(c);
      return wide[31:0];
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/seits_if.sv
// Request and response channel interfaces of the SEI timecode scanner.
`timescale 1ns / 1ps
`default_nettype none
interface seits_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_file;

   modport source (output valid, output data_byte, output end_of_file, input ready);
   modport sink   (input valid, input data_byte, input end_of_file, output ready);
endinterface

interface seits_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [63:0] time_us;
   logic [63:0] first_time_us;
   logic [7:0]  status_byte;
   logic        lock_unknown;
   logic        codec;
   logic        went_backwards;
   logic [31:0] frame_count;
   logic [31:0] backwards_count;
   logic        last_of_run;

   modport source (output valid, output kind, output time_us, output first_time_us,
                   output status_byte, output lock_unknown, output codec,
                   output went_backwards, output frame_count, output backwards_count,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input time_us, input first_time_us,
                   input status_byte, input lock_unknown, input codec,
                   input went_backwards, input frame_count, input backwards_count,
                   input last_of_run, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/seits_match.sv
// Header, identifier and payload compare over the byte window.
`timescale 1ns / 1ps
`default_nettype none
module seits_match (
   input  var seits_pkg::window_type window_bytes,
   output var seits_pkg::match_type  result
);

   logic avc_hit;
   logic hevc_hit;
   logic fill_ok;
   logic [7:0] pay [12];

   always_comb begin
      avc_hit  = 1'b1;
      hevc_hit = 1'b1;
      for (int i = 0; i < seits_pkg::ID_LEN; i++) begin
         if (window_bytes[seits_pkg::ID_BASE + i] != seits_pkg::ID_AVC[i]) begin
            avc_hit = 1'b0;
         end
         if (window_bytes[seits_pkg::ID_BASE + i] != seits_pkg::ID_HEVC[i]) begin
            hevc_hit = 1'b0;
         end
      end
      // Both headers end right before the identifier; the H.265 header starts one byte earlier.
      for (int i = 0; i < 3; i++) begin
         if (window_bytes[1 + i] != seits_pkg::HDR_AVC[i]) begin
            avc_hit = 1'b0;
         end
      end
      for (int i = 0; i < 4; i++) begin
         if (window_bytes[i] != seits_pkg::HDR_HEVC[i]) begin
            hevc_hit = 1'b0;
         end
      end
      hevc_hit = hevc_hit & ~avc_hit;

      for (int i = 0; i < 12; i++) begin
         pay[i] = window_bytes[seits_pkg::PAY_BASE + i];
      end
      fill_ok = (pay[3] == seits_pkg::FILL_BYTE) && (pay[6] == seits_pkg::FILL_BYTE) &&
                (pay[9] == seits_pkg::FILL_BYTE);

      result.found  = (avc_hit | hevc_hit) & fill_ok;
      result.hevc   = hevc_hit;
      result.stamp  = {pay[1], pay[2], pay[4], pay[5], pay[7], pay[8], pay[10], pay[11]};
      result.status = pay[0];
   end

endmodule
`default_nettype wire

FILE: hw/rtl/seits_queue.sv
// Small result queue: up to two pushes and one pop per cycle.
`timescale 1ns / 1ps
`default_nettype none
module seits_queue (
   input  var logic                   clock,
   input  var logic                   reset,
   input  var logic [1:0]             push_n,
   input  var seits_pkg::result_type  push0,
   input  var seits_pkg::result_type  push1,
   output var logic                   room,
   input  var logic                   pop,
   output var logic                   nonempty,
   output var seits_pkg::result_type  head
);

   localparam int CNT_W = seits_pkg::QPTR_W + 1;

   seits_pkg::result_type mem_ff [seits_pkg::QUEUE_DEPTH];

   logic [seits_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [seits_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [seits_pkg::QPTR_W-1:0] wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + seits_pkg::QPTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + seits_pkg::QPTR_W'(push_n);
   assign rd_ptr_in   = rd_ptr_ff + seits_pkg::QPTR_W'(pop);
   assign count_in    = count_ff + CNT_W'(push_n) - CNT_W'(pop);

   // Room for a two-result request, judged from the registered count only.
   assign room     = count_ff <= CNT_W'(seits_pkg::QUEUE_DEPTH - 2);
   assign nonempty = count_ff != '0;
   assign head     = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_next] <= push1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/sei_timecode_scanner_core.sv
// Top level of the SEI timecode scanner: byte window, statistics and result queue.
// Throughput: one request (byte) per cycle while the result queue has room; a byte that
//   yields both a frame report and the summary puts two results on the response side.
// Path: a result passes the window register, then match and statistics into the
//   result queue, from which it is presented.
// Reset (synchronous, active high) clears the window, counters, stamps, queue and
//   the report_each_frame register.
`timescale 1ns / 1ps
`default_nettype none
`include "sei_timecode_scanner_core_defines.svh"
module sei_timecode_scanner_core (
   input  var logic  clock,
   input  var logic  reset,
   seits_req_if.sink   req_bus,
   seits_rsp_if.source rsp_bus,
   input  var logic  csr_write_enable,
   input  var logic  csr_write_data
);

   localparam int CW = seits_pkg::COUNT_WIDTH;

   // ---------------------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------------------
   logic report_ff, report_in;

   assign report_in = csr_write_enable ? csr_write_data : report_ff;

   // ---------------------------------------------------------------------------
   // Stage A: sliding byte window. The window register doubles as the input
   // register of the match stage; it only moves when it holds no request or stage B consumes it.
   // ---------------------------------------------------------------------------
   seits_pkg::window_type window_ff, window_in;
   logic a_valid_ff, a_valid_in;
   logic a_eof_ff,   a_eof_in;
   logic clear_pend_ff, clear_pend_in;   // previous request closed a file
   logic req_fire;
   logic b_fire;
   logic q_room;

   assign b_fire         = a_valid_ff & q_room;
   assign req_bus.ready  = ~a_valid_ff | b_fire;
   assign req_fire       = req_bus.valid & req_bus.ready;

   always_comb begin
      window_in     = window_ff;
      a_eof_in      = a_eof_ff;
      clear_pend_in = clear_pend_ff;
      a_valid_in    = a_valid_ff & ~b_fire;
      if (req_fire) begin
         // After end of file the window restarts from zeros.
         for (int i = 0; i < seits_pkg::WIN_DEPTH - 1; i++) begin
            window_in[i] = clear_pend_ff ? 8'h00 : window_ff[i + 1];
         end
         window_in[seits_pkg::WIN_DEPTH - 1] = req_bus.data_byte;
         a_eof_in      = req_bus.end_of_file;
         clear_pend_in = req_bus.end_of_file;
         a_valid_in    = 1'b1;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage B: pattern match, statistics update, results into the queue.
   // ---------------------------------------------------------------------------
   seits_pkg::match_type mt;

   seits_match u_match (
      .window_bytes (window_ff),
      .result       (mt)
   );

   logic [CW-1:0] found_ff, found_in;
   logic [CW-1:0] rev_ff,   rev_in;
   logic [63:0]   first_ff, first_in;
   logic [63:0]   prev_ff,  prev_in;

   logic [CW-1:0] found_upd, rev_upd;
   logic [63:0]   first_upd, prev_upd;
   logic          back;
   logic          frame_hit;
   logic          sum_hit;

   seits_pkg::result_type frame_res, sum_res, slot0;
   logic [1:0] push_n;

   always_comb begin
      // First find only sets the first stamp; it never counts as backwards.
      back      = mt.found && (found_ff != '0) && (mt.stamp < prev_ff);
      first_upd = (mt.found && found_ff == '0) ? mt.stamp : first_ff;
      prev_upd  = mt.found ? mt.stamp : prev_ff;
      found_upd = (mt.found && found_ff != seits_pkg::COUNT_MAX) ?
                  found_ff + CW'(1) : found_ff;
      rev_upd   = (back && rev_ff != seits_pkg::COUNT_MAX) ? rev_ff + CW'(1) : rev_ff;

      frame_hit = b_fire & mt.found & report_ff;
      sum_hit   = b_fire & a_eof_ff;

      frame_res.kind            = seits_pkg::KIND_FRAME;
      frame_res.time_us         = mt.stamp;
      frame_res.first_time_us   = first_upd;
      frame_res.status_byte     = mt.status;
      frame_res.lock_unknown    = mt.status[7];
      frame_res.codec           = mt.hevc ? seits_pkg::CODEC_HEVC : seits_pkg::CODEC_AVC;
      frame_res.went_backwards  = back;
      frame_res.frame_count     = seits_pkg::count_to_out(found_upd);
      frame_res.backwards_count = seits_pkg::count_to_out(rev_upd);
      frame_res.last_of_run     = ~a_eof_ff;

      sum_res.kind            = seits_pkg::KIND_SUMMARY;
      sum_res.time_us         = prev_upd;
      sum_res.first_time_us   = first_upd;
      sum_res.status_byte     = 8'h00;
      sum_res.lock_unknown    = 1'b0;
      sum_res.codec           = seits_pkg::CODEC_AVC;
      sum_res.went_backwards  = rev_upd != '0;
      sum_res.frame_count     = seits_pkg::count_to_out(found_upd);
      sum_res.backwards_count = seits_pkg::count_to_out(rev_upd);
      sum_res.last_of_run     = 1'b1;

      slot0  = frame_hit ? frame_res : sum_res;
      push_n = {1'b0, frame_hit} + {1'b0, sum_hit};

      found_in = found_ff;
      rev_in   = rev_ff;
      first_in = first_ff;
      prev_in  = prev_ff;
      if (b_fire) begin
         if (a_eof_ff) begin
            // Summary sent: statistics start over for the next file.
            found_in = '0;
            rev_in   = '0;
            first_in = '0;
            prev_in  = '0;
         end else begin
            found_in = found_upd;
            rev_in   = rev_upd;
            first_in = first_upd;
            prev_in  = prev_upd;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result queue: decouples the response side so requests keep flowing.
   // ---------------------------------------------------------------------------
   seits_pkg::result_type head;
   logic q_nonempty;
   logic rsp_fire;

   assign rsp_fire = rsp_bus.valid & rsp_bus.ready;

   seits_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_n   (push_n),
      .push0    (slot0),
      .push1    (sum_res),
      .room     (q_room),
      .pop      (rsp_fire),
      .nonempty (q_nonempty),
      .head     (head)
   );

   assign rsp_bus.valid           = q_nonempty;
   assign rsp_bus.kind            = head.kind;
   assign rsp_bus.time_us         = head.time_us;
   assign rsp_bus.first_time_us   = head.first_time_us;
   assign rsp_bus.status_byte     = head.status_byte;
   assign rsp_bus.lock_unknown    = head.lock_unknown;
   assign rsp_bus.codec           = head.codec;
   assign rsp_bus.went_backwards  = head.went_backwards;
   assign rsp_bus.frame_count     = head.frame_count;
   assign rsp_bus.backwards_count = head.backwards_count;
   assign rsp_bus.last_of_run     = head.last_of_run;

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         report_ff     <= 1'b0;
         window_ff     <= '0;
         a_valid_ff    <= 1'b0;
         a_eof_ff      <= 1'b0;
         clear_pend_ff <= 1'b0;
         found_ff      <= '0;
         rev_ff        <= '0;
         first_ff      <= '0;
         prev_ff       <= '0;
      end else begin
         report_ff     <= report_in;
         window_ff     <= window_in;
         a_valid_ff    <= a_valid_in;
         a_eof_ff      <= a_eof_in;
         clear_pend_ff <= clear_pend_in;
         found_ff      <= found_in;
         rev_ff        <= rev_in;
         first_ff      <= first_in;
         prev_ff       <= prev_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------------
   // A summary always closes its request's run of results.
   `SEITS_ASSERT_IMPL(a_summary_last, clock, reset,
      rsp_bus.valid && rsp_bus.kind == seits_pkg::KIND_SUMMARY, rsp_bus.last_of_run)
   // A frame report always counts at least its own find.
   `SEITS_ASSERT_IMPL(a_frame_counted, clock, reset,
      rsp_bus.valid && rsp_bus.kind == seits_pkg::KIND_FRAME, rsp_bus.frame_count != 32'd0)
   // Statistics are clear right after a summary is queued.
   `SEITS_ASSERT_NEXT(a_eof_clears, clock, reset, sum_hit,
      found_ff == '0 && rev_ff == '0 && prev_ff == 64'd0 && first_ff == 64'd0)
   // Nothing is queued unless stage B actually consumed a request.
   `SEITS_ASSERT_IMPL(a_push_needs_fire, clock, reset, push_n != 2'd0, b_fire)

endmodule
`default_nettype wire
